// ===== src/idpr_pkg.sv =====
package idpr_pkg;

  localparam int unsigned ACC_W   = 32;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned CFG_IDX_W = 2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH    = 2'd2;

  localparam logic signed [DATA_W-1:0] RESULT_OFFSET_RST = 8'sd0;
  localparam logic signed [DATA_W-1:0] CLAMP_LOW_RST     = -8'sd128;
  localparam logic signed [DATA_W-1:0] CLAMP_HIGH_RST    = 8'sd127;

  // rounding term of the q31 high product
  localparam logic signed [PROD_W-1:0] RND_HALF = 64'sh0000_0000_4000_0000;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_MUL,
    ST_RND,
    ST_SHF,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic acc_en;
    logic load_last;
    logic mul_en;
    logic rnd_en;
    logic shf_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== src/idpr_ctrl.sv =====
module idpr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last_element,
  output logic            in_stall,
  input  idpr_pkg::sts_t  sts,
  output idpr_pkg::cmd_t  cmd
);
  import idpr_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACC: begin
        if (accept && in_last_element) state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_RND;
      ST_RND: state_nxt = ST_SHF;
      ST_SHF: state_nxt = ST_FIN;
      ST_FIN: begin
        if (sts.out_free) state_nxt = ST_ACC;
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_ACC: begin
        in_stall      = 1'b0;
        cmd.acc_en    = accept && !in_last_element;
        cmd.load_last = accept && in_last_element;
      end
      ST_MUL: cmd.mul_en = 1'b1;
      ST_RND: cmd.rnd_en = 1'b1;
      ST_SHF: cmd.shf_en = 1'b1;
      ST_FIN: cmd.out_load = sts.out_free;
      default: in_stall = 1'b1;
    endcase
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.acc_en, cmd.load_last, cmd.mul_en, cmd.rnd_en, cmd.shf_en, cmd.out_load}))
    else $error("more than one datapath command at once");

  a_last_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_last |=> cmd.mul_en ##1 cmd.rnd_en ##1 cmd.shf_en)
    else $error("requantize sequence broken");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_en || cmd.rnd_en || cmd.shf_en) |-> in_stall)
    else $error("input taken while requantizing");
`endif

endmodule

// ===== src/idpr_dpath.sv =====
module idpr_dpath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  idpr_pkg::cmd_t                         cmd,
  output idpr_pkg::sts_t                         sts,
  input  logic signed [idpr_pkg::DATA_W-1:0]     in_act_value,
  input  logic signed [idpr_pkg::DATA_W-1:0]     in_weight_value,
  input  logic signed [idpr_pkg::ACC_W-1:0]      in_channel_bias,
  input  logic signed [idpr_pkg::ACC_W-1:0]      in_channel_multiplier,
  input  logic signed [idpr_pkg::SHIFT_W-1:0]    in_channel_shift,
  input  logic                                   cfg_we,
  input  logic [idpr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [idpr_pkg::DATA_W-1:0]            cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [idpr_pkg::DATA_W-1:0]     out_value
);
  import idpr_pkg::*;

  logic        [ACC_W-1:0]          acc_r;
  logic signed [ACC_W-1:0]          sum_r;
  logic signed [ACC_W-1:0]          mult_r;
  logic signed [SHIFT_W-1:0]        shift_r;
  logic signed [PROD_W-1:0]         prod_r;
  logic signed [ACC_W-1:0]          scaled_r;
  logic signed [ACC_W-1:0]          shifted_r;
  logic signed [DATA_W-1:0]         out_value_r;
  logic                             out_valid_r;
  logic signed [DATA_W-1:0]         offset_r;
  logic signed [DATA_W-1:0]         clamp_low_r;
  logic signed [DATA_W-1:0]         clamp_high_r;

  logic signed [2*DATA_W-1:0]       mac_prod;
  logic        [ACC_W-1:0]          mac_ext;
  logic        [ACC_W-1:0]          acc_sum;
  logic signed [PROD_W-1:0]         mul_full;
  logic signed [PROD_W-1:0]         rnd_full;
  logic                             sh_right;
  logic        [ACC_W-1:0]          half;
  logic signed [ACC_W-1:0]          rnd_in;
  logic        [SHIFT_W-1:0]        left_n;
  logic signed [ACC_W-1:0]          shf_val;
  logic signed [ACC_W-1:0]          off_sum;
  logic signed [ACC_W-1:0]          lo_ext;
  logic signed [ACC_W-1:0]          hi_ext;
  logic signed [ACC_W-1:0]          clamped;

  assign mac_prod = in_act_value * in_weight_value;
  assign mac_ext  = {{(ACC_W-2*DATA_W){mac_prod[2*DATA_W-1]}}, mac_prod};
  assign acc_sum  = acc_r + mac_ext;
  assign mul_full = sum_r * mult_r;
  assign rnd_full = prod_r + RND_HALF;

  // rounding right shift for positive shift, plain left shift otherwise
  always_comb begin
    sh_right = !shift_r[SHIFT_W-1] && (shift_r != '0);
    half     = {{(ACC_W-1){1'b0}}, 1'b1} << (shift_r[4:0] - 5'd1);
    rnd_in   = scaled_r + half;
    left_n   = '0 - shift_r;
    if (sh_right) begin
      shf_val = rnd_in >>> shift_r[4:0];
    end else if (left_n[SHIFT_W-1]) begin
      shf_val = '0;
    end else begin
      shf_val = scaled_r << left_n[4:0];
    end
  end

  // low clamp first, then high, so crossed limits give clamp_high
  always_comb begin
    off_sum = shifted_r + {{(ACC_W-DATA_W){offset_r[DATA_W-1]}}, offset_r};
    lo_ext  = {{(ACC_W-DATA_W){clamp_low_r[DATA_W-1]}}, clamp_low_r};
    hi_ext  = {{(ACC_W-DATA_W){clamp_high_r[DATA_W-1]}}, clamp_high_r};
    clamped = off_sum;
    if (clamped < lo_ext) clamped = lo_ext;
    if (clamped > hi_ext) clamped = hi_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      out_valid_r  <= 1'b0;
      offset_r     <= RESULT_OFFSET_RST;
      clamp_low_r  <= CLAMP_LOW_RST;
      clamp_high_r <= CLAMP_HIGH_RST;
    end else begin
      if (cmd.acc_en) begin
        acc_r <= acc_sum;
      end else if (cmd.load_last) begin
        acc_r <= '0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RESULT_OFFSET: offset_r     <= cfg_data;
          REG_CLAMP_LOW:     clamp_low_r  <= cfg_data;
          REG_CLAMP_HIGH:    clamp_high_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_last) begin
      sum_r   <= acc_sum + in_channel_bias;
      mult_r  <= in_channel_multiplier;
      shift_r <= in_channel_shift;
    end
    if (cmd.mul_en)   prod_r      <= mul_full;
    if (cmd.rnd_en)   scaled_r    <= rnd_full[62:31];
    if (cmd.shf_en)   shifted_r   <= shf_val;
    if (cmd.out_load) out_value_r <= clamped[DATA_W-1:0];
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;

`ifndef SYNTHESIS
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_last |=> acc_r == '0)
    else $error("accumulator not cleared after last element");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result load lost");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.out_load)
    else $error("waiting result overwritten");
`endif

endmodule

// ===== src/int8_dot_product_requantize.sv =====
// int8 dot product with per-channel requantization.
// input channel: in_valid / in_stall with one activation/weight pair per
// transaction; in_last_element closes the dot product and carries the
// channel bias, q31 multiplier and signed shift.
// elements that are not last are accumulated at one per cycle while in_stall is low.
// a last element is taken in the accumulate step and then runs four
// requantize steps (32x32 multiply, rounding, shift, offset and clamp),
// during which in_stall is high. out_valid is set from a register that
// the offset and clamp step loads once the output register is free.
// output channel: out_valid / out_stall with one int8 out_value per
// transaction, held in an output register; when the receiver stalls the
// block keeps accumulating new elements and only holds a finished last
// element until the register frees.
// config channel: cfg_valid / cfg_ready (always ready), cfg_index 0 sets
// the result offset, 1 the low clamp, 2 the high clamp; index 3 is ignored.
// write config only while idle.
// reset (rst_n low, synchronous) clears the accumulator, drops out_valid and
// restores offset 0 and clamps -128..127.
module int8_dot_product_requantize (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [idpr_pkg::DATA_W-1:0]     in_act_value,
  input  logic signed [idpr_pkg::DATA_W-1:0]     in_weight_value,
  input  logic                                   in_last_element,
  input  logic signed [idpr_pkg::ACC_W-1:0]      in_channel_bias,
  input  logic signed [idpr_pkg::ACC_W-1:0]      in_channel_multiplier,
  input  logic signed [idpr_pkg::SHIFT_W-1:0]    in_channel_shift,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [idpr_pkg::DATA_W-1:0]     out_value,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [idpr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [idpr_pkg::DATA_W-1:0]            cfg_data
);
  import idpr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  idpr_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_element (in_last_element),
    .in_stall        (in_stall),
    .sts             (sts),
    .cmd             (cmd)
  );

  idpr_dpath u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_act_value          (in_act_value),
    .in_weight_value       (in_weight_value),
    .in_channel_bias       (in_channel_bias),
    .in_channel_multiplier (in_channel_multiplier),
    .in_channel_shift      (in_channel_shift),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_value             (out_value)
  );

endmodule
